/* rtl/core/inilt_pkg.sv */
// shared types and character constants for the ini line tokenizer
`timescale 1ns / 1ps
`default_nettype none
package inilt_pkg;

  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_OPEN    = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE   = 8'h5D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    MODE_LINE,
    MODE_SECTION,
    MODE_KEY,
    MODE_VALUE,
    MODE_SKIP,
    MODE_FAILED
  } mode_t;

  typedef enum logic [2:0] {
    ROLE_SPACE,
    ROLE_OPEN,
    ROLE_SECT,
    ROLE_CLOSE,
    ROLE_KEY,
    ROLE_EQUALS,
    ROLE_VALUE,
    ROLE_IGNORED
  } role_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_echo;
    logic [2:0]  role;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [15:0] section_number;
    logic        parse_error;
  } out_item_t;

  typedef struct packed {
    mode_t mode;
    logic  error_seen;
  } scan_status_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_comment(input logic [7:0] b);
    return (b == CHAR_SEMI) || (b == CHAR_HASH);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/inilt_in_stage.sv */
// input register stage holding one text byte request
`timescale 1ns / 1ps
`default_nettype none
module inilt_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire inilt_pkg::in_item_t item,
  output logic                   held_valid,
  input  wire logic              held_take,
  output inilt_pkg::in_item_t    held_item
);
  import inilt_pkg::*;

  logic     valid;
  in_item_t data;

  assign item_ready = !valid || held_take;
  assign held_valid = valid;
  assign held_item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_ready) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      data <= item;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/inilt_scan.sv */
// scan mode, counters and role decode for one byte
`timescale 1ns / 1ps
`default_nettype none
module inilt_scan #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire inilt_pkg::in_item_t item,
  output inilt_pkg::out_item_t     result,
  output inilt_pkg::scan_status_t  status
);
  import inilt_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  mode_t          mode, mode_next;
  logic           error_seen, error_next;
  logic [CW-1:0]  line_count, line_next;
  logic [CW-1:0]  column_count, column_next;
  logic [CW-1:0]  section_count, section_next;
  role_t          role;
  logic           fail;
  logic [7:0]     b;
  logic           last;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + {{(CW-1){1'b0}}, 1'b1};
  endfunction

  // clamp a counter to 16 bits for display
  function automatic logic [15:0] cap16(input logic [CW-1:0] v);
    logic [CW+15:0] ext;
    ext = {16'h0000, v};
    return (|ext[CW+15:16]) ? 16'hFFFF : ext[15:0];
  endfunction

  assign b    = item.text_byte;
  assign last = item.last_byte;

  always_comb begin
    role         = ROLE_IGNORED;
    fail         = 1'b0;
    mode_next    = mode;
    section_next = section_count;
    case (mode)
      MODE_LINE: begin
        if (is_blank(b)) begin
          role = ROLE_SPACE;
        end else if (b == CHAR_OPEN) begin
          role         = ROLE_OPEN;
          section_next = bump(section_count);
          mode_next    = MODE_SECTION;
          fail         = last;
        end else if (is_comment(b)) begin
          role      = ROLE_IGNORED;
          mode_next = MODE_SKIP;
        end else if (b == CHAR_EQUALS) begin
          role      = ROLE_EQUALS;
          mode_next = MODE_VALUE;
        end else begin
          role      = ROLE_KEY;
          mode_next = MODE_KEY;
          fail      = last;
        end
      end
      MODE_SECTION: begin
        if (b == CHAR_CLOSE) begin
          role      = ROLE_CLOSE;
          mode_next = MODE_LINE;
        end else begin
          role = ROLE_SECT;
          fail = last;
        end
      end
      MODE_KEY: begin
        if (b == CHAR_EQUALS) begin
          role      = ROLE_EQUALS;
          mode_next = MODE_VALUE;
        end else if (b == CHAR_NEWLINE || is_comment(b)) begin
          fail = 1'b1;
        end else begin
          role = ROLE_KEY;
          fail = last;
        end
      end
      MODE_VALUE: begin
        if (b == CHAR_NEWLINE) begin
          role      = ROLE_SPACE;
          mode_next = MODE_LINE;
        end else if (is_comment(b)) begin
          role      = ROLE_IGNORED;
          mode_next = MODE_SKIP;
        end else begin
          role = ROLE_VALUE;
        end
      end
      MODE_SKIP: begin
        if (b == CHAR_NEWLINE) begin
          role      = ROLE_SPACE;
          mode_next = MODE_LINE;
        end else begin
          role = ROLE_IGNORED;
        end
      end
      default: begin
        role      = ROLE_IGNORED;
        mode_next = MODE_FAILED;
      end
    endcase

    error_next = error_seen;
    if (fail) begin
      role       = ROLE_IGNORED;
      error_next = 1'b1;
      mode_next  = MODE_FAILED;
    end

    // the newline itself still belongs to the line it ends
    if (b == CHAR_NEWLINE) begin
      line_next   = bump(line_count);
      column_next = '0;
    end else begin
      line_next   = line_count;
      column_next = bump(column_count);
    end
  end

  always_comb begin
    result.byte_echo      = b;
    result.role           = role;
    result.line_number    = cap16(line_count);
    result.column_number  = cap16(column_count);
    result.section_number = cap16(section_next);
    result.parse_error    = error_next;
  end

  assign status.mode       = mode;
  assign status.error_seen = error_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_LINE;
      error_seen    <= 1'b0;
      line_count    <= '0;
      column_count  <= '0;
      section_count <= '0;
    end else if (take) begin
      mode          <= mode_next;
      error_seen    <= error_next;
      line_count    <= line_next;
      column_count  <= column_next;
      section_count <= section_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/inilt_out_stage.sv */
// result register feeding the output channel
`timescale 1ns / 1ps
`default_nettype none
module inilt_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire inilt_pkg::out_item_t load_item,
  output logic                      space,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output inilt_pkg::out_item_t      result
);
  import inilt_pkg::*;

  logic      valid;
  out_item_t data;

  assign space        = !valid || result_ready;
  assign result_valid = valid;
  assign result       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      data <= load_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ini_line_tokenizer_top.sv */
// Tokenizer for INI text: each accepted byte yields one result tagging its role
// (space, bracket, section, key, equals, value or ignored) with line, column and
// section counts and a sticky parse error. A byte is accepted every cycle while the
// output is not stalled; its result is presented after it has passed an input
// register, one pass of mode and counter logic, and a result register. Counters are
// COUNTER_WIDTH bits, saturate, and are shown capped at 65535.
`timescale 1ns / 1ps
`default_nettype none
module ini_line_tokenizer_top #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire inilt_pkg::in_item_t  item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output inilt_pkg::out_item_t      result
);
  import inilt_pkg::*;

  logic         held_valid;
  in_item_t     held_item;
  logic         space;
  logic         take;
  out_item_t    scan_result;
  scan_status_t status;

  // a held request moves on when the result register has room
  assign take = held_valid && space;

  inilt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .held_valid (held_valid),
    .held_take  (space),
    .held_item  (held_item)
  );

  inilt_scan #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (held_item),
    .result (scan_result),
    .status (status)
  );

  inilt_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (held_valid),
    .load_item    (scan_result),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    status.error_seen |=> status.error_seen)
    else $error("parse error flag cleared without reset");

  a_error_mode: assert property (@(posedge clk) disable iff (rst)
    status.error_seen |-> status.mode == MODE_FAILED)
    else $error("parse error set but scan not in failed mode");

  a_error_role: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.parse_error |-> result.role == ROLE_IGNORED)
    else $error("byte after parse error not marked ignored");

endmodule
`default_nettype wire
